// ===== rtl/fifo_thread_scheduler_core_assert.svh =====
// ----------------------------------------------------------------------------
// fifo_thread_scheduler_core_assert
// Assertion macros for the FIFO thread scheduler.
// ----------------------------------------------------------------------------
`ifndef FIFO_THREAD_SCHEDULER_CORE_ASSERT_SVH
`define FIFO_THREAD_SCHEDULER_CORE_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define FTS_ASSERT_IMPL(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
`define FTS_ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);
`else
`define FTS_ASSERT_IMPL(label, clk, rst_n, cond, msg)
`define FTS_ASSERT_NEXT(label, clk, rst_n, pre, post, msg)
`endif
`endif

// ===== rtl/fts_pkg.sv =====
// ----------------------------------------------------------------------------
// fts_pkg
// Opcodes, thread status codes, response status codes and controller/datapath interface types.
// ----------------------------------------------------------------------------
`default_nettype none
package fts_pkg;
    localparam logic [3:0] OP_INIT = 4'd0;
    localparam logic [3:0] OP_CREATE = 4'd1;
    localparam logic [3:0] OP_YIELD = 4'd2;
    localparam logic [3:0] OP_JOIN = 4'd3;
    localparam logic [3:0] OP_JOIN_ALL = 4'd4;
    localparam logic [3:0] OP_EXIT = 4'd5;
    localparam logic [3:0] OP_SEM_CREATE = 4'd6;
    localparam logic [3:0] OP_SEM_SIGNAL = 4'd7;
    localparam logic [3:0] OP_SEM_WAIT = 4'd8;
    localparam logic [3:0] OP_SEM_DESTROY = 4'd9;

    localparam logic [2:0] ST_FREE = 3'd0;
    localparam logic [2:0] ST_READY = 3'd1;
    localparam logic [2:0] ST_RUN = 3'd2;
    localparam logic [2:0] ST_JOIN = 3'd3;
    localparam logic [2:0] ST_JALL = 3'd4;
    localparam logic [2:0] ST_SEMW = 3'd5;
    localparam logic [2:0] ST_DONE = 3'd6;

    localparam logic [1:0] RS_OK = 2'd0;
    localparam logic [1:0] RS_ERR = 2'd1;
    localparam logic [1:0] RS_ALLDONE = 2'd2;

    typedef struct packed {
        logic start;
        logic scan;
        logic step;
    } t_cmd;

    typedef struct packed {
        logic scan_last;
        logic done;
    } t_stat;
endpackage
`default_nettype wire

// ===== rtl/fts_ctrl.sv =====
// ----------------------------------------------------------------------------
// fts_ctrl
// Command sequencer: accept, table scan, execute, deliver.
// ----------------------------------------------------------------------------
`default_nettype none
`include "fifo_thread_scheduler_core_assert.svh"
module fts_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output logic               o_ready,
    output logic               o_valid,
    input  wire logic          i_ready,
    output fts_pkg::t_cmd      o_cmd,
    input  wire fts_pkg::t_stat i_stat
);
    import fts_pkg::*;
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_EXEC = 2'd2;
    localparam logic [1:0] S_OUT  = 2'd3;
    logic [1:0] r_state, n_state;

    always_comb begin
        n_state = r_state;
        o_cmd = '0;
        o_ready = 1'b0;
        o_valid = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_cmd.start = 1'b1;
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_stat.scan_last) n_state = S_EXEC;
            end
            S_EXEC: begin
                o_cmd.step = 1'b1;
                if (i_stat.done) n_state = S_OUT;
            end
            S_OUT: begin
                o_valid = 1'b1;
                o_ready = i_ready;
                if (i_ready) begin
                    if (i_valid) begin
                        o_cmd.start = 1'b1;
                        n_state = S_SCAN;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else r_state <= n_state;
    end

    `FTS_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && !i_ready, o_valid, "result dropped")
    `FTS_ASSERT_IMPL(a_excl, i_clk, i_rst_n, !(o_cmd.scan && o_cmd.step), "scan and step")
    `FTS_ASSERT_NEXT(a_start, i_clk, i_rst_n, o_cmd.start, r_state == S_SCAN, "start lost")
endmodule
`default_nettype wire

// ===== rtl/fts_dp.sv =====
// ----------------------------------------------------------------------------
// fts_dp
// Thread table, ready and semaphore queues, command execution.
// ----------------------------------------------------------------------------
`default_nettype none
`include "fifo_thread_scheduler_core_assert.svh"
module fts_dp #(
    parameter int MAX_THREADS = 16,
    parameter int MAX_SEMS = 8
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire fts_pkg::t_cmd  i_cmd,
    output fts_pkg::t_stat      o_stat,
    input  wire logic [3:0]     i_opcode,
    input  wire logic [3:0]     i_target_thread,
    input  wire logic [2:0]     i_sem_slot,
    input  wire logic [7:0]     i_sem_initial,
    output logic [1:0]          o_status,
    output logic [3:0]          o_new_handle,
    output logic [3:0]          o_running_thread,
    output logic                o_running_valid
);
    import fts_pkg::*;
    localparam int TW = (MAX_THREADS > 1) ? $clog2(MAX_THREADS) : 1;
    localparam int TPW = $clog2(MAX_THREADS + 1);
    localparam int SW = (MAX_SEMS > 1) ? $clog2(MAX_SEMS) : 1;
    localparam int SAW = $clog2(MAX_SEMS + 1);

    logic [2:0]      r_tst [MAX_THREADS];
    logic [TPW-1:0]  r_par [MAX_THREADS];
    logic [TW-1:0]   r_jt  [MAX_THREADS];
    logic [TW-1:0]   r_lnk [MAX_THREADS];
    logic [TW-1:0]   r_rh, r_rt;
    logic [TPW-1:0]  r_rc;
    logic signed [8:0] r_sc [MAX_SEMS];
    logic [TW-1:0]   r_swh [MAX_SEMS];
    logic [TW-1:0]   r_swt [MAX_SEMS];
    logic [TPW-1:0]  r_swc [MAX_SEMS];
    logic [MAX_SEMS-1:0] r_siu;
    logic [SAW-1:0]  r_salloc;
    logic [TW-1:0]   r_cur;
    logic            r_pres, r_started;
    logic [TW-1:0]   r_idx;
    logic            r_free_fnd;
    logic [TW-1:0]   r_free;
    logic            r_kid_c, r_kid_p;
    logic [1:0]      r_phase;
    logic [3:0]      r_op;
    logic [3:0]      r_tgt;
    logic [2:0]      r_ss;
    logic [7:0]      r_init;
    logic [1:0]      r_status;
    logic [3:0]      r_handle;

    logic [TW-1:0] cur, par_t;
    logic [TPW-1:0] par;
    logic par_ok, sem_ok, tgt_ok;
    logic [SW-1:0] s;
    logic [TW-1:0] rpop;
    logic signed [8:0] sc_sig, sc_wait;
    logic kid_match_c, kid_match_p;
    logic [2:0] st_i;

    assign cur = r_cur;
    assign par = r_par[r_cur];
    assign par_t = par[TW-1:0];
    assign par_ok = (par < TPW'(MAX_THREADS)) &&
                    (r_tst[par_t] == ST_JOIN || r_tst[par_t] == ST_JALL);
    assign s = r_ss[SW-1:0];
    assign sem_ok = ({1'b0, r_ss} < 4'(MAX_SEMS)) && r_siu[s];
    assign tgt_ok = ({1'b0, r_tgt} < 5'(MAX_THREADS)) &&
                    (r_par[r_tgt[TW-1:0]] == TPW'(r_cur));
    assign rpop = r_rh;
    assign sc_sig = (r_sc[s] < 9'sd255) ? r_sc[s] + 9'sd1 : r_sc[s];
    assign sc_wait = (r_sc[s] != 9'sh100) ? r_sc[s] - 9'sd1 : r_sc[s];
    assign st_i = r_tst[r_idx];
    assign kid_match_c = (st_i == ST_READY || st_i == ST_JOIN || st_i == ST_JALL) &&
                         (r_par[r_idx] == TPW'(r_cur));
    assign kid_match_p = (st_i == ST_READY || st_i == ST_JOIN || st_i == ST_JALL) &&
                         (r_par[r_idx] == par);

    assign o_stat.scan_last = i_cmd.scan && (r_idx == TW'(MAX_THREADS - 1));
    assign o_stat.done = i_cmd.step && (r_phase == 2'd1);
    assign o_status = r_status;
    assign o_new_handle = r_handle;
    assign o_running_thread = r_pres ? 4'(r_cur) : 4'd0;
    assign o_running_valid = r_pres;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < MAX_THREADS; i++) begin
                r_tst[i] <= ST_FREE;
                r_par[i] <= TPW'(MAX_THREADS);
                r_jt[i] <= '0;
            end
            for (int i = 0; i < MAX_SEMS; i++) begin
                r_sc[i] <= '0;
                r_swh[i] <= '0;
                r_swt[i] <= '0;
                r_swc[i] <= '0;
            end
            r_siu <= '0;
            r_salloc <= '0;
            r_rh <= '0;
            r_rt <= '0;
            r_rc <= '0;
            r_cur <= '0;
            r_pres <= 1'b0;
            r_started <= 1'b0;
            r_idx <= '0;
            r_phase <= '0;
        end else if (i_cmd.start) begin
            r_op <= i_opcode;
            r_tgt <= i_target_thread;
            r_ss <= i_sem_slot;
            r_init <= i_sem_initial;
            r_idx <= '0;
            r_free_fnd <= 1'b0;
            r_kid_c <= 1'b0;
            r_kid_p <= 1'b0;
            r_phase <= '0;
        end else if (i_cmd.scan) begin
            if (!r_free_fnd && st_i == ST_FREE) begin
                r_free_fnd <= 1'b1;
                r_free <= r_idx;
            end
            if (kid_match_c) r_kid_c <= 1'b1;
            if (kid_match_p) r_kid_p <= 1'b1;
            r_idx <= (r_idx == TW'(MAX_THREADS - 1)) ? '0 : r_idx + 1'b1;
        end else if (i_cmd.step && r_phase == 2'd0) begin
            // run the command in phase 0; hold in phase 1
            r_phase <= 2'd1;
            r_status <= RS_ERR;
            r_handle <= '0;
            if (r_op == OP_INIT) begin
                if (!r_started) begin
                    r_started <= 1'b1;
                    r_tst[0] <= ST_RUN;
                    r_par[0] <= TPW'(MAX_THREADS);
                    r_cur <= '0;
                    r_pres <= 1'b1;
                    r_status <= RS_OK;
                end
            end else if (r_started && r_pres) begin
                case (r_op)
                    OP_CREATE: begin
                        if (r_free_fnd) begin
                            r_tst[r_free] <= ST_READY;
                            r_par[r_free] <= TPW'(cur);
                            if (r_rc == 0) r_rh <= r_free;
                            else r_lnk[r_rt] <= r_free;
                            r_rt <= r_free;
                            r_rc <= r_rc + 1'b1;
                            r_handle <= 4'(r_free);
                            r_status <= RS_OK;
                        end
                    end
                    OP_YIELD: begin
                        r_status <= RS_OK;
                        if (r_rc != 0) begin
                            r_lnk[r_rt] <= cur;
                            r_rt <= cur;
                            if (r_rc > 1) r_rh <= r_lnk[rpop];
                            else r_rh <= cur;
                            r_tst[cur] <= ST_READY;
                            r_tst[rpop] <= ST_RUN;
                            r_cur <= rpop;
                        end
                    end
                    OP_JOIN: begin
                        if (tgt_ok) begin
                            r_status <= RS_OK;
                            r_jt[cur] <= r_tgt[TW-1:0];
                            if (r_tst[r_tgt[TW-1:0]] == ST_DONE || r_rc == 0) begin
                                r_tst[cur] <= ST_RUN;
                            end else begin
                                r_tst[cur] <= ST_JOIN;
                                if (r_rc > 1) r_rh <= r_lnk[rpop];
                                r_rc <= r_rc - 1'b1;
                                r_tst[rpop] <= ST_RUN;
                                r_cur <= rpop;
                            end
                        end
                    end
                    OP_JOIN_ALL: begin
                        r_status <= RS_OK;
                        if (!r_kid_c || r_rc == 0) begin
                            r_tst[cur] <= ST_RUN;
                        end else begin
                            r_tst[cur] <= ST_JALL;
                            if (r_rc > 1) r_rh <= r_lnk[rpop];
                            r_rc <= r_rc - 1'b1;
                            r_tst[rpop] <= ST_RUN;
                            r_cur <= rpop;
                        end
                    end
                    OP_EXIT: begin
                        r_status <= RS_OK;
                        r_tst[cur] <= ST_DONE;
                        if (par_ok) begin
                            if ((r_tst[par_t] == ST_JOIN ?
                                 (r_jt[par_t] == cur) : !r_kid_p) || r_rc == 0) begin
                                r_tst[par_t] <= ST_RUN;
                                r_cur <= par_t;
                            end else begin
                                if (r_rc > 1) r_rh <= r_lnk[rpop];
                                r_rc <= r_rc - 1'b1;
                                r_tst[rpop] <= ST_RUN;
                                r_cur <= rpop;
                            end
                        end else if (r_rc == 0) begin
                            r_pres <= 1'b0;
                            r_cur <= '0;
                            r_status <= RS_ALLDONE;
                        end else begin
                            if (r_rc > 1) r_rh <= r_lnk[rpop];
                            r_rc <= r_rc - 1'b1;
                            r_tst[rpop] <= ST_RUN;
                            r_cur <= rpop;
                        end
                    end
                    OP_SEM_CREATE: begin
                        if (r_salloc < SAW'(MAX_SEMS)) begin
                            r_salloc <= r_salloc + 1'b1;
                            r_siu[r_salloc[SW-1:0]] <= 1'b1;
                            r_sc[r_salloc[SW-1:0]] <= {1'b0, r_init};
                            r_swc[r_salloc[SW-1:0]] <= '0;
                            r_swh[r_salloc[SW-1:0]] <= '0;
                            r_swt[r_salloc[SW-1:0]] <= '0;
                            r_handle <= 4'(r_salloc);
                            r_status <= RS_OK;
                        end
                    end
                    OP_SEM_SIGNAL: begin
                        if (sem_ok) begin
                            r_status <= RS_OK;
                            r_sc[s] <= sc_sig;
                            if (sc_sig <= 9'sd0 && r_swc[s] != 0) begin
                                if (r_swc[s] > 1) r_swh[s] <= r_lnk[r_swh[s]];
                                r_swc[s] <= r_swc[s] - 1'b1;
                                r_tst[r_swh[s]] <= ST_READY;
                                if (r_rc == 0) r_rh <= r_swh[s];
                                else r_lnk[r_rt] <= r_swh[s];
                                r_rt <= r_swh[s];
                                r_rc <= r_rc + 1'b1;
                            end
                        end
                    end
                    OP_SEM_WAIT: begin
                        if (sem_ok) begin
                            r_status <= RS_OK;
                            r_sc[s] <= sc_wait;
                            if (sc_wait < 9'sd0 && r_rc != 0) begin
                                r_tst[cur] <= ST_SEMW;
                                if (r_swc[s] == 0) r_swh[s] <= cur;
                                else r_lnk[r_swt[s]] <= cur;
                                r_swt[s] <= cur;
                                r_swc[s] <= r_swc[s] + 1'b1;
                                if (r_rc > 1) r_rh <= r_lnk[rpop];
                                r_rc <= r_rc - 1'b1;
                                r_tst[rpop] <= ST_RUN;
                                r_cur <= rpop;
                            end
                        end
                    end
                    OP_SEM_DESTROY: begin
                        if (sem_ok && r_swc[s] == 0) begin
                            r_siu[s] <= 1'b0;
                            r_status <= RS_OK;
                        end
                    end
                    default: ;
                endcase
            end
        end
    end

    `FTS_ASSERT_IMPL(a_rc_range, i_clk, i_rst_n, r_rc <= TPW'(MAX_THREADS), "ready overflow")
    `FTS_ASSERT_IMPL(a_pres_started, i_clk, i_rst_n, !r_pres || r_started, "run before init")
    `FTS_ASSERT_NEXT(a_status, i_clk, i_rst_n, o_stat.done, r_status != 2'd3, "bad status")
endmodule
`default_nettype wire

// ===== rtl/fifo_thread_scheduler_core.sv =====
// ----------------------------------------------------------------------------
// fifo_thread_scheduler_core
// Cooperative FIFO thread scheduler with counting semaphores.
// ----------------------------------------------------------------------------
// One command at a time: accept, a scan of all MAX_THREADS slots of the
// thread table (one slot per cycle), execute, then the result is held until
// taken. The next command is accepted only when the previous result is taken.
`default_nettype none
module fifo_thread_scheduler_core #(
    parameter int MAX_THREADS = 16,
    parameter int MAX_SEMS = 8
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output logic            o_ready,
    input  wire logic [3:0] i_opcode,
    input  wire logic [3:0] i_target_thread,
    input  wire logic [2:0] i_sem_slot,
    input  wire logic [7:0] i_sem_initial,
    output logic            o_valid,
    input  wire logic       i_ready,
    output logic [1:0]      o_status,
    output logic [3:0]      o_new_handle,
    output logic [3:0]      o_running_thread,
    output logic            o_running_valid
);
    import fts_pkg::*;
    t_cmd w_cmd;
    t_stat w_stat;

    fts_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_ready(o_ready),
        .o_valid(o_valid), .i_ready(i_ready), .o_cmd(w_cmd), .i_stat(w_stat)
    );

    fts_dp #(.MAX_THREADS(MAX_THREADS), .MAX_SEMS(MAX_SEMS)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(w_cmd), .o_stat(w_stat),
        .i_opcode(i_opcode), .i_target_thread(i_target_thread),
        .i_sem_slot(i_sem_slot), .i_sem_initial(i_sem_initial),
        .o_status(o_status), .o_new_handle(o_new_handle),
        .o_running_thread(o_running_thread), .o_running_valid(o_running_valid)
    );
endmodule
`default_nettype wire

// ===== tb/sv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the cooperative FIFO thread scheduler core.
// ----------------------------------------------------------------------------
// A directed command sequence is followed by random commands. The random part
// is mostly creates, yields, joins and semaphore traffic, with rare exits.
// Each accepted request is run through a behavioral scheduler model kept in
// the bench. Every response is compared field by field with the oldest
// prediction. The sender issues requests in bursts with random gaps, and
// pauses once until every response is back. The receiver stalls in shifting
// patterns and holds off once for a long stretch.
// ----------------------------------------------------------------------------
module tb_top;
    import fts_pkg::*;

    localparam int NTHR = 16;
    localparam int NSEM = 8;
    localparam int IDLE_LIMIT = 5000;

    typedef struct {
        logic [3:0] opcode;
        logic [3:0] target;
        logic [2:0] slot;
        logic [7:0] initial_cnt;
        bit         drain;
    } cmd_t;

    typedef struct {
        logic [1:0] status;
        logic [3:0] handle;
        logic [3:0] run_thr;
        logic       run_v;
    } resp_t;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_valid = 1'b0;
    logic [3:0] i_opcode = '0;
    logic [3:0] i_target_thread = '0;
    logic [2:0] i_sem_slot = '0;
    logic [7:0] i_sem_initial = '0;
    logic       i_ready = 1'b0;
    logic       o_ready;
    logic       o_valid;
    logic [1:0] o_status;
    logic [3:0] o_new_handle;
    logic [3:0] o_running_thread;
    logic       o_running_valid;

    fifo_thread_scheduler_core uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_ready(o_ready),
        .i_opcode(i_opcode), .i_target_thread(i_target_thread),
        .i_sem_slot(i_sem_slot), .i_sem_initial(i_sem_initial),
        .o_valid(o_valid), .i_ready(i_ready),
        .o_status(o_status), .o_new_handle(o_new_handle),
        .o_running_thread(o_running_thread), .o_running_valid(o_running_valid)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // scheduler model state
    logic [2:0] thr_state[NTHR];
    logic [4:0] thr_parent[NTHR];
    logic [3:0] thr_join[NTHR];
    logic [3:0] ready_fifo[$];
    logic [3:0] semw_fifo[NSEM][$];
    int         sem_value[NSEM];
    bit         sem_live[NSEM];
    int         sem_next;
    logic [3:0] cur_thr;
    bit         cur_live;
    bit         booted;

    cmd_t  cmd_q[$];
    resp_t resp_q[$];
    int    pending_n = 0;
    int    resp_seen = 0;
    bit    failed = 0;

    function automatic void model_clear();
        for (int i = 0; i < NTHR; i++) begin
            thr_state[i] = ST_FREE;
            thr_parent[i] = 5'(NTHR);
            thr_join[i] = '0;
        end
        for (int i = 0; i < NSEM; i++) begin
            sem_value[i] = 0;
            sem_live[i] = 0;
            semw_fifo[i].delete();
        end
        ready_fifo.delete();
        cur_thr = '0;
        cur_live = 0;
        booted = 0;
        sem_next = 0;
    endfunction

    function automatic void dispatch_ready();
        logic [3:0] th;
        th = ready_fifo.pop_front();
        thr_state[th] = ST_RUN;
        cur_thr = th;
        cur_live = 1;
    endfunction

    function automatic bit has_live_child(logic [3:0] p);
        for (int i = 0; i < NTHR; i++)
            if (thr_parent[i] == {1'b0, p} &&
                (thr_state[i] == ST_READY || thr_state[i] == ST_JOIN ||
                 thr_state[i] == ST_JALL))
                return 1;
        return 0;
    endfunction

    function automatic void resolve_join(logic [3:0] p);
        bit met;
        if (thr_state[p] == ST_JOIN)
            met = thr_state[thr_join[p]] == ST_DONE;
        else
            met = !has_live_child(p);
        if (met || ready_fifo.size() == 0) begin
            thr_state[p] = ST_RUN;
            cur_thr = p;
            cur_live = 1;
        end else begin
            dispatch_ready();
        end
    endfunction

    function automatic resp_t schedule_cmd(cmd_t c);
        resp_t r;
        logic [3:0] cur;
        logic [4:0] par;
        int s;
        r.status = RS_ERR;
        r.handle = '0;
        cur = cur_thr;
        s = c.slot;
        if (c.opcode == OP_INIT) begin
            if (!booted) begin
                booted = 1;
                thr_state[0] = ST_RUN;
                thr_parent[0] = 5'(NTHR);
                cur_thr = '0;
                cur_live = 1;
                r.status = RS_OK;
            end
        end else if (booted && cur_live) begin
            case (c.opcode)
                OP_CREATE: begin
                    for (int i = 0; i < NTHR; i++) begin
                        if (thr_state[i] == ST_FREE) begin
                            thr_state[i] = ST_READY;
                            thr_parent[i] = {1'b0, cur};
                            ready_fifo.push_back(4'(i));
                            r.handle = 4'(i);
                            r.status = RS_OK;
                            break;
                        end
                    end
                end
                OP_YIELD: begin
                    if (ready_fifo.size() != 0) begin
                        thr_state[cur] = ST_READY;
                        ready_fifo.push_back(cur);
                        dispatch_ready();
                    end
                    r.status = RS_OK;
                end
                OP_JOIN: begin
                    if (thr_parent[c.target] == {1'b0, cur}) begin
                        thr_state[cur] = ST_JOIN;
                        thr_join[cur] = c.target;
                        resolve_join(cur);
                        r.status = RS_OK;
                    end
                end
                OP_JOIN_ALL: begin
                    thr_state[cur] = ST_JALL;
                    resolve_join(cur);
                    r.status = RS_OK;
                end
                OP_EXIT: begin
                    par = thr_parent[cur];
                    thr_state[cur] = ST_DONE;
                    r.status = RS_OK;
                    if (par < NTHR && (thr_state[par[3:0]] == ST_JOIN ||
                                       thr_state[par[3:0]] == ST_JALL)) begin
                        resolve_join(par[3:0]);
                    end else if (ready_fifo.size() == 0) begin
                        cur_live = 0;
                        cur_thr = '0;
                        r.status = RS_ALLDONE;
                    end else begin
                        dispatch_ready();
                    end
                end
                OP_SEM_CREATE: begin
                    if (sem_next < NSEM) begin
                        sem_live[sem_next] = 1;
                        sem_value[sem_next] = c.initial_cnt;
                        semw_fifo[sem_next].delete();
                        r.handle = 4'(sem_next);
                        sem_next++;
                        r.status = RS_OK;
                    end
                end
                OP_SEM_SIGNAL: begin
                    if (sem_live[s]) begin
                        if (sem_value[s] < 255) sem_value[s]++;
                        if (sem_value[s] <= 0 && semw_fifo[s].size() != 0) begin
                            logic [3:0] th;
                            th = semw_fifo[s].pop_front();
                            thr_state[th] = ST_READY;
                            ready_fifo.push_back(th);
                        end
                        r.status = RS_OK;
                    end
                end
                OP_SEM_WAIT: begin
                    if (sem_live[s]) begin
                        if (sem_value[s] > -256) sem_value[s]--;
                        if (sem_value[s] < 0 && ready_fifo.size() != 0) begin
                            thr_state[cur] = ST_SEMW;
                            semw_fifo[s].push_back(cur);
                            dispatch_ready();
                        end
                        r.status = RS_OK;
                    end
                end
                OP_SEM_DESTROY: begin
                    if (sem_live[s] && semw_fifo[s].size() == 0) begin
                        sem_live[s] = 0;
                        r.status = RS_OK;
                    end
                end
                default: ;
            endcase
        end
        r.run_thr = cur_live ? cur_thr : 4'd0;
        r.run_v = cur_live;
        return r;
    endfunction

    function automatic cmd_t mk_cmd(logic [3:0] op, logic [3:0] tg, logic [2:0] sl,
                                    logic [7:0] iv, bit dr);
        cmd_t c;
        c.opcode = op;
        c.target = tg;
        c.slot = sl;
        c.initial_cnt = iv;
        c.drain = dr;
        return c;
    endfunction

    function automatic cmd_t rand_cmd();
        cmd_t c;
        int w;
        w = $urandom_range(0, 99);
        c = mk_cmd(OP_YIELD, 4'($urandom), 3'($urandom), 8'($urandom), 0);
        if (w < 1) c.opcode = OP_INIT;
        else if (w < 20) c.opcode = OP_CREATE;
        else if (w < 36) c.opcode = OP_YIELD;
        else if (w < 46) c.opcode = OP_JOIN;
        else if (w < 51) c.opcode = OP_JOIN_ALL;
        else if (w < 53) c.opcode = OP_EXIT;
        else if (w < 57) c.opcode = OP_SEM_CREATE;
        else if (w < 75) c.opcode = OP_SEM_SIGNAL;
        else if (w < 93) c.opcode = OP_SEM_WAIT;
        else if (w < 96) c.opcode = OP_SEM_DESTROY;
        else c.opcode = 4'($urandom_range(10, 15));
        case ($urandom_range(0, 3))
            0: c.initial_cnt = 8'd0;
            1: c.initial_cnt = 8'($urandom_range(0, 3));
            2: c.initial_cnt = 8'd255;
            default: ;
        endcase
        if ($urandom_range(0, 2) != 0) c.slot = 3'($urandom_range(0, 2));
        return c;
    endfunction

    // sender
    int burst_left = 0;
    int gap_left = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!(i_valid && !o_ready)) begin
            if (gap_left > 0) begin
                gap_left <= gap_left - 1;
                i_valid <= 1'b0;
            end else if (cmd_q.size() == 0) begin
                i_valid <= 1'b0;
            end else if (cmd_q[0].drain && (i_valid || pending_n != 0)) begin
                i_valid <= 1'b0;
            end else begin
                cmd_t c;
                c = cmd_q.pop_front();
                i_valid <= 1'b1;
                i_opcode <= c.opcode;
                i_target_thread <= c.target;
                i_sem_slot <= c.slot;
                i_sem_initial <= c.initial_cnt;
                if (burst_left <= 1) begin
                    burst_left <= $urandom_range(1, 12);
                    gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 30);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end
        end
    end

    // receiver
    int rx_cyc = 0;
    int hold_left = 0;
    bit held = 0;
    always @(posedge i_clk) begin
        rx_cyc <= rx_cyc + 1;
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            i_ready <= 1'b0;
        end else if (!held && resp_seen >= 300) begin
            held <= 1;
            hold_left <= 300;
            i_ready <= 1'b0;
        end else begin
            case (rx_cyc[10:9])
                2'd0: i_ready <= 1'b1;
                2'd1: i_ready <= ($urandom_range(0, 1) == 0);
                2'd2: i_ready <= ($urandom_range(0, 7) == 0);
                default: i_ready <= rx_cyc[2];
            endcase
        end
    end

    // response check and prediction
    int idle_cycles = 0;
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && i_ready) begin
                resp_seen <= resp_seen + 1;
                if (resp_q.size() == 0) begin
                    $error("response with no request outstanding");
                    failed = 1;
                end else begin
                    resp_t e;
                    e = resp_q.pop_front();
                    if (o_status !== e.status) begin
                        $error("status exp %0d got %0d", e.status, o_status);
                        failed = 1;
                    end
                    if (o_new_handle !== e.handle) begin
                        $error("new_handle exp %0d got %0d", e.handle, o_new_handle);
                        failed = 1;
                    end
                    if (o_running_thread !== e.run_thr) begin
                        $error("running_thread exp %0d got %0d", e.run_thr,
                               o_running_thread);
                        failed = 1;
                    end
                    if (o_running_valid !== e.run_v) begin
                        $error("running_valid exp %0d got %0d", e.run_v,
                               o_running_valid);
                        failed = 1;
                    end
                end
            end
            if (i_valid && o_ready)
                resp_q.push_back(schedule_cmd(mk_cmd(i_opcode, i_target_thread,
                                                     i_sem_slot, i_sem_initial, 0)));
            pending_n <= resp_q.size();
            if ((o_valid && i_ready) || (i_valid && o_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    always @(posedge i_clk) begin
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial begin
        model_clear();
        // directed
        cmd_q.push_back(mk_cmd(OP_CREATE, 4'd0, 3'd0, 8'd0, 0));
        cmd_q.push_back(mk_cmd(OP_SEM_SIGNAL, 4'd0, 3'd0, 8'd0, 0));
        cmd_q.push_back(mk_cmd(OP_INIT, 4'd0, 3'd0, 8'd0, 0));
        cmd_q.push_back(mk_cmd(OP_INIT, 4'd0, 3'd0, 8'd0, 0));
        cmd_q.push_back(mk_cmd(OP_YIELD, 4'd0, 3'd0, 8'd0, 0));
        cmd_q.push_back(mk_cmd(OP_JOIN, 4'd15, 3'd0, 8'd0, 0));
        cmd_q.push_back(mk_cmd(OP_JOIN_ALL, 4'd0, 3'd0, 8'd0, 0));
        cmd_q.push_back(mk_cmd(OP_SEM_WAIT, 4'd0, 3'd7, 8'd0, 0));
        cmd_q.push_back(mk_cmd(OP_SEM_CREATE, 4'd0, 3'd0, 8'd255, 0));
        cmd_q.push_back(mk_cmd(OP_SEM_SIGNAL, 4'd0, 3'd0, 8'd0, 0));
        cmd_q.push_back(mk_cmd(OP_SEM_CREATE, 4'd0, 3'd0, 8'd0, 0));
        cmd_q.push_back(mk_cmd(OP_SEM_WAIT, 4'd0, 3'd1, 8'd0, 0));
        cmd_q.push_back(mk_cmd(OP_CREATE, 4'd0, 3'd0, 8'd0, 0));
        cmd_q.push_back(mk_cmd(OP_CREATE, 4'd0, 3'd0, 8'd0, 0));
        cmd_q.push_back(mk_cmd(OP_SEM_WAIT, 4'd0, 3'd1, 8'd0, 0));
        cmd_q.push_back(mk_cmd(OP_SEM_DESTROY, 4'd0, 3'd1, 8'd0, 0));
        cmd_q.push_back(mk_cmd(OP_SEM_SIGNAL, 4'd0, 3'd1, 8'd0, 0));
        cmd_q.push_back(mk_cmd(OP_JOIN, 4'd2, 3'd0, 8'd0, 0));
        cmd_q.push_back(mk_cmd(OP_EXIT, 4'd0, 3'd0, 8'd0, 0));
        cmd_q.push_back(mk_cmd(OP_JOIN_ALL, 4'd0, 3'd0, 8'd0, 0));
        cmd_q.push_back(mk_cmd(4'd15, 4'd15, 3'd7, 8'd255, 0));
        cmd_q.push_back(mk_cmd(4'd10, 4'd0, 3'd0, 8'd0, 0));
        cmd_q.push_back(mk_cmd(OP_SEM_DESTROY, 4'd0, 3'd0, 8'd0, 0));
        cmd_q.push_back(mk_cmd(OP_SEM_SIGNAL, 4'd0, 3'd0, 8'd0, 0));
        // random
        for (int n = 0; n < 1250; n++) begin
            cmd_t c;
            c = rand_cmd();
            c.drain = (n == 600);
            cmd_q.push_back(c);
        end
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        while (cmd_q.size() != 0 || i_valid || pending_n != 0 || resp_q.size() != 0)
            @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (!failed && resp_q.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule

// ===== fifo_thread_scheduler_core.f =====
+incdir+rtl
rtl/fts_pkg.sv
rtl/fts_ctrl.sv
rtl/fts_dp.sv
rtl/fifo_thread_scheduler_core.sv
tb/sv/tb_top.sv
